// ===== rtl/ffca_pkg.sv =====
// Shared types and constants for the first-fit coalescing allocator.
// Used by ffca_ctrl, ffca_datapath and first_fit_coalescing_allocator_unit.
`timescale 1ns / 1ps
package ffca_pkg;

    localparam int UNITS      = 1024;
    // UNIT_BYTES must be a power of two: unit counts and byte counts convert by shifting.
    localparam int UNIT_BYTES = 64;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int AW         = $clog2(UNITS);
    localparam int LW         = AW + 1;
    localparam int SIZE_W     = 17;
    localparam int BYTES_W    = 17;
    localparam int UNITS_W    = SIZE_W + 1 - UNIT_SHIFT;

    localparam logic CMD_FREE = 1'b1;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_NOFIT = 2'd1,
        RES_ZERO  = 2'd2
    } t_res;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_CHK,
        S_A_TAKE,
        S_A_SP1,
        S_A_SP2,
        S_F_CHK,
        S_F_NX,
        S_F_NX2,
        S_F_TAG,
        S_F_PRD,
        S_F_PCHK,
        S_F_APP0,
        S_F_APP1,
        S_F_APP2,
        S_DONE_OK,
        S_DONE_NOFIT,
        S_DONE_ZERO
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_DECODE,
        OP_A_CHK,
        OP_A_TAKE,
        OP_A_SP1,
        OP_A_SP2,
        OP_F_CHK,
        OP_F_NX,
        OP_F_NX2,
        OP_F_TAG,
        OP_F_PRD,
        OP_F_PCHK,
        OP_F_APP0,
        OP_F_APP1,
        OP_F_APP2,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        logic free_cmd;
        logic size_zero;
        logic count_zero;
        logic h_oob;
        logic fit;
        logic exact;
        logic last;
        logic used_h;
        logic nx_in;
        logic nx_free;
        logic nx_single;
        logic h_zero;
        logic p_lt_h;
        logic p_free;
        logic merged;
    } t_sts;

endpackage

// ===== rtl/first_fit_coalescing_allocator_unit.sv =====
// Top level of the first-fit allocator with boundary-tag coalescing.
// Depends on ffca_pkg, ffca_ctrl and ffca_datapath.
//
//   Channel   Handshake                Payload
//   command   start / busy             i_cmd, i_size_bytes, i_unit_index
//   result    o_valid (one cycle)      o_status, o_alloc_unit, o_used_bytes
//   config    i_cfg_valid/o_cfg_ready  i_cfg_data (pool size in units)
//
// An allocate is decoded, walks the free blocks in list order, and takes one whole or
// splits it. The free-list walk reads the block tables once per cycle. A free of a used
// block marks it free and merges it with free neighbours or else links it into the free list.
// After reset and after every config write the tables are swept, one unit per cycle, over
// all 1024 units with busy high. The result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [ffca_pkg::AW-1:0]       i_unit_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffca_pkg::LW-1:0]       i_cfg_data,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [ffca_pkg::AW-1:0]       o_alloc_unit,
    output logic [ffca_pkg::BYTES_W-1:0]  o_used_bytes
);

    ffca_pkg::t_cmd w_cmd;
    ffca_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ffca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ffca_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_free   (i_cmd),
        .i_size_bytes (i_size_bytes),
        .i_unit_index (i_unit_index),
        .i_cfg_wr     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_sts        (w_sts),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_alloc_unit (o_alloc_unit),
        .o_used_bytes (o_used_bytes)
    );

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid) |=> busy)
        else $error("accepted item did not raise busy");

    a_nofit_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ffca_pkg::RES_OK)) |-> (o_alloc_unit == '0))
        else $error("failed request reports an allocated unit");
`endif

endmodule

// ===== rtl/ffca_ctrl.sv =====
// Sequencer of the allocator: walks each item through its datapath steps.
// Depends on ffca_pkg; drives ffca_datapath through t_cmd and reads t_sts.
`timescale 1ns / 1ps
module ffca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ffca_pkg::t_sts i_sts,
    output ffca_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    ffca_pkg::t_state r_state;
    ffca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffca_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffca_pkg::S_CLEAR:  if (i_sts.clr_last) n_state = ffca_pkg::S_IDLE;
            ffca_pkg::S_IDLE:   if (i_start) n_state = ffca_pkg::S_DECODE;
            ffca_pkg::S_DECODE: begin
                if (i_sts.free_cmd) begin
                    n_state = i_sts.h_oob ? ffca_pkg::S_DONE_OK : ffca_pkg::S_F_CHK;
                end else if (i_sts.size_zero) begin
                    n_state = ffca_pkg::S_DONE_ZERO;
                end else if (i_sts.count_zero) begin
                    n_state = ffca_pkg::S_DONE_NOFIT;
                end else begin
                    n_state = ffca_pkg::S_A_CHK;
                end
            end
            ffca_pkg::S_A_CHK: begin
                if (i_sts.fit) begin
                    n_state = i_sts.exact ? ffca_pkg::S_A_TAKE : ffca_pkg::S_A_SP1;
                end else if (i_sts.last) begin
                    n_state = ffca_pkg::S_DONE_NOFIT;
                end
            end
            ffca_pkg::S_A_TAKE: n_state = ffca_pkg::S_DONE_OK;
            ffca_pkg::S_A_SP1:  n_state = ffca_pkg::S_A_SP2;
            ffca_pkg::S_A_SP2:  n_state = ffca_pkg::S_DONE_OK;
            ffca_pkg::S_F_CHK: begin
                if (!i_sts.used_h) begin
                    n_state = ffca_pkg::S_DONE_OK;
                end else begin
                    n_state = i_sts.nx_in ? ffca_pkg::S_F_NX : ffca_pkg::S_F_TAG;
                end
            end
            ffca_pkg::S_F_NX: begin
                if (i_sts.nx_free && !i_sts.nx_single) n_state = ffca_pkg::S_F_NX2;
                else n_state = ffca_pkg::S_F_TAG;
            end
            ffca_pkg::S_F_NX2: n_state = ffca_pkg::S_F_TAG;
            ffca_pkg::S_F_TAG: n_state = i_sts.h_zero ? ffca_pkg::S_F_APP0 : ffca_pkg::S_F_PRD;
            ffca_pkg::S_F_PRD: n_state = i_sts.p_lt_h ? ffca_pkg::S_F_PCHK : ffca_pkg::S_F_APP0;
            ffca_pkg::S_F_PCHK: begin
                n_state = i_sts.p_free ? ffca_pkg::S_DONE_OK : ffca_pkg::S_F_APP0;
            end
            ffca_pkg::S_F_APP0: begin
                if (i_sts.merged || i_sts.count_zero) n_state = ffca_pkg::S_DONE_OK;
                else n_state = ffca_pkg::S_F_APP1;
            end
            ffca_pkg::S_F_APP1: n_state = ffca_pkg::S_F_APP2;
            ffca_pkg::S_F_APP2: n_state = ffca_pkg::S_DONE_OK;
            ffca_pkg::S_DONE_OK, ffca_pkg::S_DONE_NOFIT, ffca_pkg::S_DONE_ZERO: begin
                n_state = ffca_pkg::S_IDLE;
            end
            default: n_state = ffca_pkg::S_CLEAR;
        endcase
        // A pool write restarts the clearing sweep from any state.
        if (i_sts.cfg_wr) n_state = ffca_pkg::S_CLEAR;
    end

    always_comb begin
        o_cmd.res = ffca_pkg::RES_OK;
        unique case (r_state)
            ffca_pkg::S_CLEAR:  o_cmd.op = ffca_pkg::OP_CLEAR;
            ffca_pkg::S_IDLE:   o_cmd.op = i_start ? ffca_pkg::OP_LOAD : ffca_pkg::OP_NONE;
            ffca_pkg::S_DECODE: o_cmd.op = ffca_pkg::OP_DECODE;
            ffca_pkg::S_A_CHK:  o_cmd.op = ffca_pkg::OP_A_CHK;
            ffca_pkg::S_A_TAKE: o_cmd.op = ffca_pkg::OP_A_TAKE;
            ffca_pkg::S_A_SP1:  o_cmd.op = ffca_pkg::OP_A_SP1;
            ffca_pkg::S_A_SP2:  o_cmd.op = ffca_pkg::OP_A_SP2;
            ffca_pkg::S_F_CHK:  o_cmd.op = ffca_pkg::OP_F_CHK;
            ffca_pkg::S_F_NX:   o_cmd.op = ffca_pkg::OP_F_NX;
            ffca_pkg::S_F_NX2:  o_cmd.op = ffca_pkg::OP_F_NX2;
            ffca_pkg::S_F_TAG:  o_cmd.op = ffca_pkg::OP_F_TAG;
            ffca_pkg::S_F_PRD:  o_cmd.op = ffca_pkg::OP_F_PRD;
            ffca_pkg::S_F_PCHK: o_cmd.op = ffca_pkg::OP_F_PCHK;
            ffca_pkg::S_F_APP0: o_cmd.op = ffca_pkg::OP_F_APP0;
            ffca_pkg::S_F_APP1: o_cmd.op = ffca_pkg::OP_F_APP1;
            ffca_pkg::S_F_APP2: o_cmd.op = ffca_pkg::OP_F_APP2;
            ffca_pkg::S_DONE_OK: o_cmd.op = ffca_pkg::OP_DONE;
            ffca_pkg::S_DONE_NOFIT: begin
                o_cmd.op  = ffca_pkg::OP_DONE;
                o_cmd.res = ffca_pkg::RES_NOFIT;
            end
            ffca_pkg::S_DONE_ZERO: begin
                o_cmd.op  = ffca_pkg::OP_DONE;
                o_cmd.res = ffca_pkg::RES_ZERO;
            end
            default: o_cmd.op = ffca_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != ffca_pkg::S_IDLE);

endmodule

// ===== rtl/ffca_datapath.sv =====
// Datapath of the allocator: per-unit block tables, list registers and result registers.
// Depends on ffca_pkg; executes one t_cmd step per cycle and reports t_sts.
`timescale 1ns / 1ps
module ffca_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffca_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_free,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [ffca_pkg::AW-1:0]       i_unit_index,
    input  logic                          i_cfg_wr,
    input  logic [ffca_pkg::LW-1:0]       i_cfg_data,
    output ffca_pkg::t_sts                o_sts,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [ffca_pkg::AW-1:0]       o_alloc_unit,
    output logic [ffca_pkg::BYTES_W-1:0]  o_used_bytes
);

    localparam int AW  = ffca_pkg::AW;
    localparam int LW  = ffca_pkg::LW;
    localparam int UW  = ffca_pkg::UNITS_W;
    localparam int BW  = ffca_pkg::BYTES_W;
    localparam int SW  = ffca_pkg::SIZE_W;
    localparam int XW  = UW + LW;

    // Block tables, one entry per unit.
    logic [LW-1:0] mem_len  [ffca_pkg::UNITS];
    logic          mem_free [ffca_pkg::UNITS];
    logic          mem_used [ffca_pkg::UNITS];
    logic [AW-1:0] mem_tag  [ffca_pkg::UNITS];
    logic [AW-1:0] mem_next [ffca_pkg::UNITS];
    logic [AW-1:0] mem_prev [ffca_pkg::UNITS];

    logic [LW-1:0] r_rd_len;
    logic          r_rd_free;
    logic          r_rd_used;
    logic [AW-1:0] r_rd_tag;
    logic [AW-1:0] r_rd_next;
    logic [AW-1:0] r_rd_prev;

    logic [LW-1:0] r_pool;
    logic [AW-1:0] r_head;
    logic [LW-1:0] r_count;
    logic [BW-1:0] r_bytes;
    logic [AW-1:0] r_clr;
    logic          r_free_cmd;
    logic          r_size_zero;
    logic [UW-1:0] r_units;
    logic [AW-1:0] r_h;
    logic [AW-1:0] r_cur;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_len;
    logic [AW-1:0] r_n;
    logic [AW-1:0] r_p;
    logic [AW-1:0] r_nx;
    logic          r_merged;
    logic [AW-1:0] r_hn;
    logic [AW-1:0] r_hp;
    logic [AW-1:0] r_pp;
    logic [AW-1:0] r_alloc;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [AW-1:0] r_alloc_out;
    logic [BW-1:0] r_used_out;

    logic [AW-1:0] w_rd_addr;
    logic          w_len_we,  w_free_we, w_used_we, w_tag_we, w_next_we, w_prev_we;
    logic [AW-1:0] w_len_a,   w_free_a,  w_used_a,  w_tag_a,  w_next_a,  w_prev_a;
    logic [LW-1:0] w_len_d;
    logic          w_free_d,  w_used_d;
    logic [AW-1:0] w_tag_d,   w_next_d,  w_prev_d;

    logic [SW:0]   w_size_sum;
    logic [UW-1:0] w_units_in;
    logic [BW-1:0] w_alloc_bytes;
    logic [BW-1:0] w_free_bytes;
    logic [LW:0]   w_nx;
    logic [LW:0]   w_i_inc;
    logic          w_fit;
    logic          w_nx_single;
    logic [AW-1:0] w_rest;
    logic [LW-1:0] w_newlen;
    logic [LW-1:0] w_cfg_pool;
    logic          w_cur_single;

    assign w_size_sum    = (SW + 1)'(i_size_bytes) + (SW + 1)'(ffca_pkg::UNIT_BYTES - 1);
    assign w_units_in    = UW'(w_size_sum >> ffca_pkg::UNIT_SHIFT);
    assign w_alloc_bytes = BW'((SW + 1)'(r_units) << ffca_pkg::UNIT_SHIFT);
    assign w_free_bytes  = BW'((SW + 1)'(r_rd_len) << ffca_pkg::UNIT_SHIFT);
    assign w_nx          = (LW + 1)'(r_h) + (LW + 1)'(r_rd_len);
    assign w_i_inc       = (LW + 1)'(r_i) + (LW + 1)'(1);
    assign w_fit         = XW'(r_rd_len) >= XW'(r_units);
    assign w_nx_single   = (r_rd_next == r_nx);
    assign w_rest        = AW'(XW'(r_cur) + XW'(r_units));
    assign w_newlen      = r_len + r_rd_len;
    assign w_cur_single  = (r_n == r_cur);

    always_comb begin
        w_cfg_pool = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_cfg_pool = LW'(1);
        end else if (i_cfg_data > LW'(ffca_pkg::UNITS)) begin
            w_cfg_pool = LW'(ffca_pkg::UNITS);
        end
    end

    always_comb begin
        case (i_cmd.op)
            ffca_pkg::OP_DECODE: w_rd_addr = r_free_cmd ? r_h : r_head;
            ffca_pkg::OP_A_CHK:  w_rd_addr = r_rd_next;
            ffca_pkg::OP_F_CHK:  w_rd_addr = AW'(w_nx);
            ffca_pkg::OP_F_TAG:  w_rd_addr = r_h - AW'(1);
            ffca_pkg::OP_F_PRD:  w_rd_addr = r_rd_tag;
            default:             w_rd_addr = r_head;
        endcase
    end

    // Table write ports: at most one write per table in any step.
    always_comb begin
        w_len_we  = 1'b0; w_len_a  = '0; w_len_d  = '0;
        w_free_we = 1'b0; w_free_a = '0; w_free_d = 1'b0;
        w_used_we = 1'b0; w_used_a = '0; w_used_d = 1'b0;
        w_tag_we  = 1'b0; w_tag_a  = '0; w_tag_d  = '0;
        w_next_we = 1'b0; w_next_a = '0; w_next_d = '0;
        w_prev_we = 1'b0; w_prev_a = '0; w_prev_d = '0;
        case (i_cmd.op)
            ffca_pkg::OP_CLEAR: begin
                w_len_we  = 1'b1; w_len_a  = r_clr; w_len_d = (r_clr == '0) ? r_pool : '0;
                w_free_we = 1'b1; w_free_a = r_clr; w_free_d = (r_clr == '0);
                w_used_we = 1'b1; w_used_a = r_clr;
                w_tag_we  = 1'b1; w_tag_a  = r_clr;
                w_next_we = 1'b1; w_next_a = r_clr;
                w_prev_we = 1'b1; w_prev_a = r_clr;
            end
            ffca_pkg::OP_A_TAKE: begin
                w_free_we = 1'b1; w_free_a = r_cur; w_free_d = 1'b0;
                w_used_we = 1'b1; w_used_a = r_cur; w_used_d = 1'b1;
                if (!w_cur_single) begin
                    w_next_we = 1'b1; w_next_a = r_p; w_next_d = r_n;
                    w_prev_we = 1'b1; w_prev_a = r_n; w_prev_d = r_p;
                end
            end
            ffca_pkg::OP_A_SP1: begin
                w_len_we  = 1'b1; w_len_a  = r_cur; w_len_d = LW'(r_units);
                w_tag_we  = 1'b1; w_tag_a  = AW'(XW'(r_cur) + XW'(r_units) - XW'(1));
                w_tag_d   = r_cur;
                w_free_we = 1'b1; w_free_a = r_cur; w_free_d = 1'b0;
                w_used_we = 1'b1; w_used_a = r_cur; w_used_d = 1'b1;
                w_next_we = 1'b1; w_next_d = w_rest;
                w_prev_we = 1'b1; w_prev_d = w_rest;
                w_next_a  = w_cur_single ? w_rest : r_p;
                w_prev_a  = w_cur_single ? w_rest : r_n;
            end
            ffca_pkg::OP_A_SP2: begin
                w_len_we  = 1'b1; w_len_a  = w_rest; w_len_d = LW'(XW'(r_len) - XW'(r_units));
                w_tag_we  = 1'b1; w_tag_a  = AW'(XW'(r_cur) + XW'(r_len) - XW'(1));
                w_tag_d   = w_rest;
                w_free_we = 1'b1; w_free_a = w_rest; w_free_d = 1'b1;
                w_used_we = 1'b1; w_used_a = w_rest; w_used_d = 1'b0;
                if (!w_cur_single) begin
                    w_next_we = 1'b1; w_next_a = w_rest; w_next_d = r_n;
                    w_prev_we = 1'b1; w_prev_a = w_rest; w_prev_d = r_p;
                end
            end
            ffca_pkg::OP_F_CHK: begin
                if (r_rd_used) begin
                    w_free_we = 1'b1; w_free_a = r_h; w_free_d = 1'b1;
                    w_used_we = 1'b1; w_used_a = r_h; w_used_d = 1'b0;
                end
            end
            ffca_pkg::OP_F_NX: begin
                if (r_rd_free) begin
                    w_len_we  = 1'b1; w_len_a  = r_h; w_len_d = w_newlen;
                    w_free_we = 1'b1; w_free_a = r_nx; w_free_d = 1'b0;
                    w_tag_we  = 1'b1; w_tag_a  = AW'(XW'(r_h) + XW'(w_newlen) - XW'(1));
                    w_tag_d   = r_h;
                    w_next_we = 1'b1; w_next_d = r_h;
                    w_prev_we = 1'b1; w_prev_d = r_h;
                    w_next_a  = w_nx_single ? r_h : r_rd_prev;
                    w_prev_a  = w_nx_single ? r_h : r_rd_next;
                end
            end
            ffca_pkg::OP_F_NX2: begin
                w_next_we = 1'b1; w_next_a = r_h; w_next_d = r_hn;
                w_prev_we = 1'b1; w_prev_a = r_h; w_prev_d = r_hp;
            end
            ffca_pkg::OP_F_PCHK: begin
                if (r_rd_free) begin
                    w_len_we  = 1'b1; w_len_a  = r_pp; w_len_d = r_rd_len + r_len;
                    w_tag_we  = 1'b1; w_tag_a  = AW'(XW'(r_h) + XW'(r_len) - XW'(1));
                    w_tag_d   = r_pp;
                    w_free_we = 1'b1; w_free_a = r_h; w_free_d = 1'b0;
                    if (r_merged && (r_hn != r_h)) begin
                        w_next_we = 1'b1; w_next_a = r_hp; w_next_d = r_hn;
                        w_prev_we = 1'b1; w_prev_a = r_hn; w_prev_d = r_hp;
                    end
                end
            end
            ffca_pkg::OP_F_APP0: begin
                if (!r_merged && (r_count == '0)) begin
                    w_next_we = 1'b1; w_next_a = r_h; w_next_d = r_h;
                    w_prev_we = 1'b1; w_prev_a = r_h; w_prev_d = r_h;
                end
            end
            ffca_pkg::OP_F_APP1: begin
                w_next_we = 1'b1; w_next_a = r_rd_prev; w_next_d = r_h;
                w_prev_we = 1'b1; w_prev_a = r_h;       w_prev_d = r_rd_prev;
            end
            ffca_pkg::OP_F_APP2: begin
                w_next_we = 1'b1; w_next_a = r_h;    w_next_d = r_head;
                w_prev_we = 1'b1; w_prev_a = r_head; w_prev_d = r_h;
            end
            default: begin
                w_len_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) mem_len[w_len_a] <= w_len_d;
        r_rd_len <= mem_len[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_free_we) mem_free[w_free_a] <= w_free_d;
        r_rd_free <= mem_free[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_used_we) mem_used[w_used_a] <= w_used_d;
        r_rd_used <= mem_used[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) mem_tag[w_tag_a] <= w_tag_d;
        r_rd_tag <= mem_tag[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) mem_next[w_next_a] <= w_next_d;
        r_rd_next <= mem_next[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) mem_prev[w_prev_a] <= w_prev_d;
        r_rd_prev <= mem_prev[w_rd_addr];
    end

    // Pool-wide control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool  <= LW'(ffca_pkg::UNITS);
            r_head  <= '0;
            r_count <= LW'(1);
            r_bytes <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else if (i_cfg_wr) begin
            r_pool  <= w_cfg_pool;
            r_head  <= '0;
            r_count <= LW'(1);
            r_bytes <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == ffca_pkg::OP_DONE);
            case (i_cmd.op)
                ffca_pkg::OP_CLEAR: r_clr <= r_clr + AW'(1);
                ffca_pkg::OP_A_TAKE: begin
                    if (!w_cur_single && (r_head == r_cur)) r_head <= r_n;
                    if (r_count != '0) r_count <= r_count - LW'(1);
                    r_bytes <= r_bytes + w_alloc_bytes;
                end
                ffca_pkg::OP_A_SP2: begin
                    if (r_head == r_cur) r_head <= w_rest;
                    r_bytes <= r_bytes + w_alloc_bytes;
                end
                ffca_pkg::OP_F_CHK: begin
                    if (r_rd_used) r_bytes <= r_bytes - w_free_bytes;
                end
                ffca_pkg::OP_F_NX: begin
                    if (r_rd_free && (r_head == r_nx)) r_head <= r_h;
                end
                ffca_pkg::OP_F_PCHK: begin
                    if (r_rd_free && r_merged) begin
                        if ((r_hn != r_h) && (r_head == r_h)) r_head <= r_hn;
                        if (r_count != '0) r_count <= r_count - LW'(1);
                    end
                end
                ffca_pkg::OP_F_APP0: begin
                    if (!r_merged && (r_count == '0)) begin
                        r_head  <= r_h;
                        r_count <= r_count + LW'(1);
                    end
                end
                ffca_pkg::OP_F_APP2: r_count <= r_count + LW'(1);
                default: r_clr <= r_clr;
            endcase
        end
    end

    // Per-item working registers and result payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffca_pkg::OP_LOAD: begin
                r_free_cmd  <= (i_cmd_free == ffca_pkg::CMD_FREE);
                r_size_zero <= (i_size_bytes == '0);
                r_units     <= w_units_in;
                r_h         <= i_unit_index;
                r_merged    <= 1'b0;
                r_alloc     <= '0;
            end
            ffca_pkg::OP_DECODE: begin
                r_cur <= r_head;
                r_i   <= '0;
            end
            ffca_pkg::OP_A_CHK: begin
                if (w_fit) begin
                    r_len <= r_rd_len;
                    r_n   <= r_rd_next;
                    r_p   <= r_rd_prev;
                end else begin
                    r_cur <= r_rd_next;
                    r_i   <= LW'(w_i_inc);
                end
            end
            ffca_pkg::OP_A_TAKE, ffca_pkg::OP_A_SP2: r_alloc <= r_cur;
            ffca_pkg::OP_F_CHK: begin
                r_len <= r_rd_len;
                r_nx  <= AW'(w_nx);
            end
            ffca_pkg::OP_F_NX: begin
                if (r_rd_free) begin
                    r_merged <= 1'b1;
                    r_len    <= w_newlen;
                    r_hn     <= w_nx_single ? r_h : r_rd_next;
                    r_hp     <= w_nx_single ? r_h : r_rd_prev;
                end
            end
            ffca_pkg::OP_F_PRD: r_pp <= r_rd_tag;
            ffca_pkg::OP_DONE: begin
                r_status    <= i_cmd.res;
                r_alloc_out <= r_alloc;
                r_used_out  <= r_bytes;
            end
            default: r_pp <= r_pp;
        endcase
    end

    always_comb begin
        o_sts.cfg_wr     = i_cfg_wr;
        o_sts.clr_last   = (r_clr == AW'(ffca_pkg::UNITS - 1));
        o_sts.free_cmd   = r_free_cmd;
        o_sts.size_zero  = r_size_zero;
        o_sts.count_zero = (r_count == '0);
        o_sts.h_oob      = (LW'(r_h) >= r_pool);
        o_sts.fit        = w_fit;
        o_sts.exact      = (XW'(r_rd_len) == XW'(r_units));
        o_sts.last       = (w_i_inc >= (LW + 1)'(r_count))
                        || (w_i_inc >= (LW + 1)'(ffca_pkg::UNITS));
        o_sts.used_h     = r_rd_used;
        o_sts.nx_in      = (w_nx < (LW + 1)'(r_pool));
        o_sts.nx_free    = r_rd_free;
        o_sts.nx_single  = w_nx_single;
        o_sts.h_zero     = (r_h == '0);
        o_sts.p_lt_h     = (r_rd_tag < r_h);
        o_sts.p_free     = r_rd_free;
        o_sts.merged     = r_merged;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_alloc_unit = r_alloc_out;
    assign o_used_bytes = r_used_out;

endmodule
